// File: rtl/fsyn_pkg.sv
// Shared types, codes and elaboration-time table builders for the
// Fourier waveform synthesizer. No dependencies.
`default_nettype none
package fsyn_pkg;

  localparam int NUM_HARMONICS  = 16;
  localparam int COS_TABLE_BITS = 10;
  localparam int CUSTOM_DEPTH   = 16;
  localparam int CUSTOM_AW      = 4;
  localparam int SAMPLE_W       = 24;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned INV_PI_Q30  = 64'd341782638;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TRAP_A_Q16  = 64'd567485;
  localparam longint unsigned TRAP_B_Q16  = 64'd1370031;
  // 1/pi^2 in Q30, rounded to nearest
  localparam longint unsigned INV_PI2_Q30 = (INV_PI_Q30 * INV_PI_Q30 + Q30_ONE / 2) / Q30_ONE;

  typedef enum logic [2:0] {
    WAVE_CUSTOM    = 3'd0,
    WAVE_SQUARE    = 3'd1,
    WAVE_TRIANGLE  = 3'd2,
    WAVE_SAW_LEFT  = 3'd3,
    WAVE_SAW_RIGHT = 3'd4,
    WAVE_TRAPEZOID = 3'd5
  } wave_e;

  typedef enum logic [1:0] {
    CFG_WAVE_TYPE  = 2'd0,
    CFG_PHASE_STEP = 2'd1,
    CFG_GAIN       = 2'd2,
    CFG_DC_OFFSET  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_GAIN,
    ST_ROUND
  } state_e;

  typedef struct packed {
    logic               operation;
    logic [3:0]         entry_index;
    logic [7:0]         harmonic_number;
    logic signed [15:0] amplitude;
    logic [15:0]        phase_offset;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               bad_type;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         harm;
    logic signed [15:0] amp;
    logic [15:0]        poff;
  } custom_entry_t;

  // multiple of the fundamental and Q12 weight of one series term
  typedef struct packed {
    logic [7:0]         mult;
    logic signed [15:0] amp;
  } term_t;

  function automatic longint unsigned kern_cos(longint unsigned g);
    longint unsigned x, x2, c;
    x  = (g * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    c  = Q30_ONE / 40320;
    c  = Q30_ONE / 720 - ((x2 * c) >> 30);
    c  = Q30_ONE / 24 - ((x2 * c) >> 30);
    c  = Q30_ONE / 2 - ((x2 * c) >> 30);
    return Q30_ONE - ((x2 * c) >> 30);
  endfunction

  function automatic longint unsigned kern_sin(longint unsigned g);
    longint unsigned x, x2, c;
    x  = (g * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    c  = Q30_ONE / 362880;
    c  = Q30_ONE / 5040 - ((x2 * c) >> 30);
    c  = Q30_ONE / 120 - ((x2 * c) >> 30);
    c  = Q30_ONE / 6 - ((x2 * c) >> 30);
    c  = Q30_ONE - ((x2 * c) >> 30);
    return (x * c) >> 30;
  endfunction

  function automatic logic [15:0] to_q15(longint unsigned v);
    longint unsigned r;
    r = (v + 64'd16384) >> 15;
    return (r > 64'd32767) ? 16'd32767 : r[15:0];
  endfunction

  // first-quadrant cosine (or sine) entry j of a table with 2^bits phases
  function automatic logic [15:0] cos_quarter(int j, int bits, bit want_sin);
    longint unsigned f, c, s;
    f = longint'(j) << (32 - bits);
    if (f < (Q30_ONE >> 1)) begin
      c = kern_cos(f);
      s = kern_sin(f);
    end else begin
      c = kern_sin(Q30_ONE - f);
      s = kern_cos(Q30_ONE - f);
    end
    return want_sin ? to_q15(s) : to_q15(c);
  endfunction

  function automatic logic [7:0] stock_mult(int wt, int i);
    return (wt == 1 || wt == 2) ? 8'(2 * i - 1) : 8'(i);
  endfunction

  // numerator of the Q12 weight of term i of a stock shape
  function automatic longint unsigned stock_num(int wt, int i);
    int m;
    m = i % 16;
    case (wt)
      1:       return 64'd16384 * INV_PI_Q30;
      2:       return 64'd32768 * INV_PI2_Q30;
      3, 4:    return 64'd8192 * INV_PI_Q30;
      default: begin
        if ((i % 2) == 0) return 64'd0;
        return (m == 1 || m == 7 || m == 9 || m == 15) ? TRAP_A_Q16 * INV_PI2_Q30
                                                       : TRAP_B_Q16 * INV_PI2_Q30;
      end
    endcase
  endfunction

  // denominator of the Q12 weight of term i of a stock shape
  function automatic longint unsigned stock_den(int wt, int i);
    longint unsigned k;
    k = longint'(stock_mult(wt, i));
    case (wt)
      1, 3, 4: return k << 30;
      2:       return (k * k) << 30;
      default: return (k * k) << 34;
    endcase
  endfunction

  // sign of the weight of term i of a stock shape
  function automatic bit stock_neg(int wt, int i);
    bit odd;
    int m;
    odd = (i % 2) != 0;
    m   = i % 16;
    case (wt)
      1:       return 1'b0;
      2, 3:    return !odd;
      4:       return odd;
      default: return !(m == 3 || m == 5 || m == 9 || m == 15);
    endcase
  endfunction

endpackage
`default_nettype wire

// File: rtl/fsyn_if.sv
// Valid/ready stream interfaces for the synthesizer input and result channels.
// Depends on fsyn_pkg for the payload types.
`default_nettype none
interface fsyn_in_if;
  import fsyn_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fsyn_out_if;
  import fsyn_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/fsyn_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module fsyn_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/fsyn_cos_rom.sv
// Q1.15 cosine of the top table bits of a 32-bit phase, from quarter-wave
// constant tables built at elaboration. Depends on fsyn_pkg.
`default_nettype none
module fsyn_cos_rom import fsyn_pkg::*; #(
  parameter int CosTableBits = COS_TABLE_BITS
) (
  input  wire logic [31:0]        phase_i,
  output      logic signed [15:0] cos_o
);
  localparam int QW = CosTableBits - 2;
  localparam int QN = 1 << QW;

  logic [15:0] c_tab [QN];
  logic [15:0] s_tab [QN];

  for (genvar j = 0; j < QN; j++) begin : g_tab
    assign c_tab[j] = cos_quarter(j, CosTableBits, 1'b0);
    assign s_tab[j] = cos_quarter(j, CosTableBits, 1'b1);
  end

  logic [QW-1:0] j_idx;
  logic [15:0]   c_val, s_val;

  assign j_idx = phase_i[29 -: QW];
  assign c_val = c_tab[j_idx];
  assign s_val = s_tab[j_idx];

  always_comb begin
    case (phase_i[31:30])
      2'd0:    cos_o = $signed(c_val);
      2'd1:    cos_o = -$signed(s_val);
      2'd2:    cos_o = -$signed(c_val);
      default: cos_o = $signed(s_val);
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/fsyn_coef_rom.sv
// Stock-shape Fourier series weights (Q12) and harmonic multiples, as
// constant tables indexed by wave type and term. Depends on fsyn_pkg.
`default_nettype none
module fsyn_coef_rom import fsyn_pkg::*; #(
  parameter int NumHarmonics = NUM_HARMONICS,
  parameter int IdxW         = 7
) (
  input  wire logic [2:0]      wave_i,
  input  wire logic [IdxW-1:0] idx_i,
  output      term_t           term_o
);
  localparam int NW = 5;
  localparam int TW = $clog2(NumHarmonics);

  term_t tab [NW][NumHarmonics];

  for (genvar w = 0; w < NW; w++) begin : g_wave
    for (genvar i = 0; i < NumHarmonics; i++) begin : g_term
      if (i == 0) begin : g_zero
        assign tab[w][i] = '0;
      end else begin : g_val
        localparam longint unsigned NUM = stock_num(w + 1, i);
        localparam longint unsigned DEN = stock_den(w + 1, i);
        localparam longint unsigned MAG = (NUM + DEN / 2) / DEN;
        localparam logic signed [15:0] AMP = stock_neg(w + 1, i) ? -16'(MAG) : 16'(MAG);
        assign tab[w][i] = '{mult: stock_mult(w + 1, i), amp: AMP};
      end
    end
  end

  logic          in_range;
  logic [TW-1:0] t_idx;
  assign in_range = int'(idx_i) < NumHarmonics;
  assign t_idx    = idx_i[TW-1:0];

  always_comb begin
    term_o = '0;
    if (in_range) begin
      unique case (wave_i)
        WAVE_SQUARE:    term_o = tab[0][t_idx];
        WAVE_TRIANGLE:  term_o = tab[1][t_idx];
        WAVE_SAW_LEFT:  term_o = tab[2][t_idx];
        WAVE_SAW_RIGHT: term_o = tab[3][t_idx];
        WAVE_TRAPEZOID: term_o = tab[4][t_idx];
        default:        term_o = '0;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/fourier_waveform_synthesizer.sv
// Top level of the additive harmonic waveform synthesizer.
// Depends on fsyn_pkg, fsyn_if, fsyn_ram, fsyn_cos_rom and fsyn_coef_rom.
//
// Usage:
//   in_s carries one transaction per operation: a tick produces one sample,
//   a write stores one custom harmonic entry (harmonic, amplitude, phase)
//   and produces nothing. out_s carries {sample, bad_type} for each tick.
//   Configuration (wave type, phase step, gain, dc offset) is written on
//   cfg_we_i/cfg_idx_i/cfg_data_i while no tick is in flight.
// Timing:
//   A tick walks one term per cycle through a four-stage term pipeline
//   (table read, phase multiply, cosine lookup, multiply-accumulate) over
//   T terms, with T = 16 for the custom table and NumHarmonics-1 otherwise;
//   once the pipeline drains, a gain multiply and a round/saturate step
//   follow. An invalid wave type skips the terms and the gain multiply.
//   A new transaction is taken once the previous tick has reached the
//   output register.
// Reset: phase accumulator zero, custom table empty (reads as zero),
//   wave type square, unit gain, no offset. No clearing pass is needed.
// Stall: a result waits in the output register; a finished tick holds in
//   its round state until the register frees, and the input stays blocked.
`default_nettype none
module fourier_waveform_synthesizer import fsyn_pkg::*; #(
  parameter int NumHarmonics = NUM_HARMONICS,
  parameter int CosTableBits = COS_TABLE_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  fsyn_in_if.sink          in_s,
  fsyn_out_if.source       out_s,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam int MaxTerms = (CUSTOM_DEPTH > NumHarmonics - 1) ? CUSTOM_DEPTH
                                                             : NumHarmonics - 1;
  localparam int CNT_W = $clog2(MaxTerms + 1);
  localparam int ACC_W = 32 + $clog2(MaxTerms);
  localparam int GW    = ACC_W + 16;
  localparam int SH_W  = GW - 23;
  localparam int YW    = SH_W + 1;

  // configuration
  logic [2:0]         wave_q;
  logic [31:0]        step_q;
  logic signed [15:0] gain_q;
  logic signed [23:0] dc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= WAVE_SQUARE;
      step_q <= '0;
      gain_q <= 16'sd256;
      dc_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WAVE_TYPE:  wave_q <= cfg_data_i[2:0];
        CFG_PHASE_STEP: step_q <= cfg_data_i;
        CFG_GAIN:       gain_q <= cfg_data_i[15:0];
        CFG_DC_OFFSET:  dc_q   <= cfg_data_i[23:0];
        default:        ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, n_terms;
  logic [2:0]       pipe_v_q;
  logic             bad_q, bad_wave, is_custom, issue;
  logic             in_acc, tick_acc, wr_acc, out_load;
  logic [31:0]      pa_q, pa_work_q;
  logic [CUSTOM_DEPTH-1:0] vld_tab_q;

  assign is_custom = wave_q == WAVE_CUSTOM;
  assign bad_wave  = wave_q > WAVE_TRAPEZOID;
  assign n_terms   = is_custom ? CNT_W'(CUSTOM_DEPTH) : CNT_W'(NumHarmonics - 1);
  assign in_s.ready = state_q == ST_IDLE;
  assign in_acc    = in_s.valid && in_s.ready;
  assign tick_acc  = in_acc && (op_e'(in_s.data.operation) == OP_TICK);
  assign wr_acc    = in_acc && (op_e'(in_s.data.operation) == OP_WRITE);
  assign issue     = (state_q == ST_RUN) && (cnt_q < n_terms);

  // custom table
  custom_entry_t wr_entry, rd_entry;
  logic [$bits(custom_entry_t)-1:0] rd_raw;

  assign wr_entry = '{harm: in_s.data.harmonic_number,
                      amp:  in_s.data.amplitude,
                      poff: in_s.data.phase_offset};

  fsyn_ram #(
    .Width($bits(custom_entry_t)),
    .Depth(CUSTOM_DEPTH)
  ) u_custom_ram (
    .clk_i   (clk_i),
    .we_i    (wr_acc),
    .waddr_i (in_s.data.entry_index),
    .wdata_i (wr_entry),
    .raddr_i (cnt_q[CUSTOM_AW-1:0]),
    .rdata_o (rd_raw)
  );
  assign rd_entry = rd_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_tab_q <= '0;
    else if (wr_acc) vld_tab_q[in_s.data.entry_index] <= 1'b1;
  end

  // stage A: term phase
  logic [CNT_W-1:0]   idx_a_q;
  logic               vld_a_q;
  term_t              stock_term;
  logic [7:0]         mult_a;
  logic signed [15:0] amp_a;
  logic [31:0]        off_a;
  logic [39:0]        mul_a;

  fsyn_coef_rom #(
    .NumHarmonics(NumHarmonics),
    .IdxW(CNT_W)
  ) u_coef_rom (
    .wave_i (wave_q),
    .idx_i  (idx_a_q),
    .term_o (stock_term)
  );

  always_comb begin
    if (is_custom) begin
      mult_a = vld_a_q ? rd_entry.harm : '0;
      amp_a  = vld_a_q ? rd_entry.amp : '0;
      off_a  = vld_a_q ? {rd_entry.poff, 16'h0000} : '0;
    end else begin
      mult_a = stock_term.mult;
      amp_a  = stock_term.amp;
      off_a  = 32'hC000_0000;  // minus a quarter turn: sine from cosine
    end
    mul_a = mult_a * pa_work_q;
  end

  // stage B: cosine lookup, stage C: multiply-accumulate
  logic [31:0]        ph_b_q;
  logic signed [15:0] amp_b_q, amp_c_q, cos_c_q, cos_b;
  logic signed [31:0] prod_c;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [GW-1:0]    gp_q;

  fsyn_cos_rom #(.CosTableBits(CosTableBits)) u_cos_rom (
    .phase_i (ph_b_q),
    .cos_o   (cos_b)
  );

  assign prod_c = amp_c_q * cos_c_q;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      idx_a_q <= is_custom ? cnt_q : cnt_q + CNT_W'(1);
      vld_a_q <= vld_tab_q[cnt_q[CUSTOM_AW-1:0]];
    end
    ph_b_q  <= mul_a[31:0] + off_a;
    amp_b_q <= amp_a;
    cos_c_q <= cos_b;
    amp_c_q <= amp_b_q;
    gp_q    <= acc_q * gain_q;
  end

  // round, offset and saturate
  logic signed [GW-1:0] rnd_sum;
  logic signed [YW-1:0] y;
  logic signed [23:0]   y_sat;
  logic                 ovf_hi, ovf_lo;

  always_comb begin
    rnd_sum = gp_q + GW'(1 << 22);
    y = $signed({rnd_sum[GW-1], rnd_sum[GW-1:23]})
      + $signed({{(YW - 24){dc_q[23]}}, dc_q});
    ovf_hi = !y[YW-1] && (|y[YW-2:23]);
    ovf_lo = y[YW-1] && !(&y[YW-2:23]);
    if (ovf_hi)      y_sat = 24'sh7FFFFF;
    else if (ovf_lo) y_sat = -24'sh800000;
    else             y_sat = y[23:0];
  end

  // control
  assign out_load = (state_q == ST_ROUND) && (!out_s.valid || out_s.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (tick_acc) state_d = bad_wave ? ST_ROUND : ST_RUN;
      ST_RUN:   if (cnt_q == n_terms && pipe_v_q == '0) state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_ROUND;
      ST_ROUND: if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      pipe_v_q <= '0;
      bad_q    <= 1'b0;
      acc_q    <= '0;
      pa_q     <= '0;
    end else begin
      pipe_v_q <= {pipe_v_q[1:0], issue};
      if (tick_acc) begin
        cnt_q <= '0;
        acc_q <= '0;
        bad_q <= bad_wave;
        pa_q  <= pa_q + step_q;
      end else begin
        if (issue) cnt_q <= cnt_q + CNT_W'(1);
        if (pipe_v_q[2]) acc_q <= acc_q + {{(ACC_W - 32){prod_c[31]}}, prod_c};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) pa_work_q <= pa_q;
  end

  // output register
  logic      out_valid_q;
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (out_s.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.sample   <= bad_q ? '0 : y_sat;
      out_data_q.bad_type <= bad_q;
    end
  end

  assign out_s.valid = out_valid_q;
  assign out_s.data  = out_data_q;

  // checks
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> pipe_v_q == '0)
    else $error("term pipeline busy while idle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> cnt_q <= n_terms)
    else $error("term counter past last term");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_acc |=> pa_q == $past(pa_q))
    else $error("phase accumulator moved without a tick");

  a_gain_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GAIN |-> $past(pipe_v_q) == '0)
    else $error("gain stage started before accumulation finished");
endmodule
`default_nettype wire
